// File: hw/rtl/wbps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_pkg
// Shared constants, register indexes and types of the wildcard byte scanner.
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int MaxPattern  = 32;
  localparam int OffsetBits  = 32;
  localparam int ByteW       = 8;
  localparam int RegW        = 64;
  localparam int WildW       = 32;
  localparam int LenW        = 6;
  localparam int RegIdxW     = 3;
  localparam int ResOffW     = 32;
  localparam int IdxW        = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int BytesPerReg = RegW / ByteW;
  localparam int NumPatRegs  = 4;

  localparam logic [RegIdxW-1:0] RegPat0 = 3'd0;
  localparam logic [RegIdxW-1:0] RegPat1 = 3'd1;
  localparam logic [RegIdxW-1:0] RegPat2 = 3'd2;
  localparam logic [RegIdxW-1:0] RegPat3 = 3'd3;
  localparam logic [RegIdxW-1:0] RegWild = 3'd4;
  localparam logic [RegIdxW-1:0] RegLen  = 3'd5;

  typedef struct packed {
    logic [MaxPattern-1:0][ByteW-1:0] pat;
    logic [MaxPattern-1:0]            wild;
    logic [IdxW-1:0]                  len_m1;
  } cfg_t;

endpackage

// File: hw/rtl/wbps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_cell
// One pattern position: compares the byte and holds its partial-match bit.
// ----------------------------------------------------------------------------
module wbps_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     clr_i,
  input  logic                     prev_i,
  input  logic                     en_i,
  input  logic                     wild_i,
  input  logic [wbps_pkg::ByteW-1:0] pat_i,
  input  logic [wbps_pkg::ByteW-1:0] byte_i,
  output logic                     match_o,
  output logic                     state_o
);
  import wbps_pkg::*;

  logic pm_q, pm_d;

  assign pm_d    = prev_i & en_i & (wild_i | (pat_i == byte_i));
  assign match_o = pm_d;
  assign state_o = pm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_q <= 1'b0;
    end else if (adv_i) begin
      pm_q <= clr_i ? 1'b0 : pm_d;
    end
  end

endmodule

// File: hw/rtl/wbps_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbps_cfg
// Configuration registers; presents pattern, wildcards and clamped length.
// ----------------------------------------------------------------------------
module wbps_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [wbps_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [wbps_pkg::RegW-1:0]    cfg_data_i,
  output wbps_pkg::cfg_t               cfg_o
);
  import wbps_pkg::*;

  logic [NumPatRegs-1:0][RegW-1:0] pat_q;
  logic [WildW-1:0]                wild_q;
  logic [LenW-1:0]                 len_q;
  logic [LenW-1:0]                 len_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      wild_q <= '0;
      len_q  <= LenW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPat0: pat_q[0] <= cfg_data_i;
        RegPat1: pat_q[1] <= cfg_data_i;
        RegPat2: pat_q[2] <= cfg_data_i;
        RegPat3: pat_q[3] <= cfg_data_i;
        RegWild: wild_q   <= cfg_data_i[WildW-1:0];
        RegLen:  len_q    <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (len_q == '0) begin
      len_eff = LenW'(1);
    end else if (len_q > LenW'(MaxPattern)) begin
      len_eff = LenW'(MaxPattern);
    end else begin
      len_eff = len_q;
    end
  end

  always_comb begin
    for (int j = 0; j < MaxPattern; j++) begin
      cfg_o.pat[j]  = pat_q[j / BytesPerReg][(j % BytesPerReg) * ByteW +: ByteW];
      cfg_o.wild[j] = wild_q[j];
    end
    cfg_o.len_m1 = IdxW'(len_eff - LenW'(1));
  end

endmodule

// File: hw/rtl/wildcard_byte_pattern_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_pattern_scanner
// Streams region bytes through a row of match cells and reports the offset
// of the first occurrence of a wildcard byte pattern.
// ----------------------------------------------------------------------------
// A result is registered for the master side in the cycle after the byte
//   that completes the match, or the region's last byte, is accepted.
// Throughput: one byte per cycle; all cells compare in parallel each cycle.
// The input stalls only while a result sits in the output register untaken.
// Reset clears the cells, the offset counter and the output valid flag, and
//   returns the pattern registers to zero and the length to one.
module wildcard_byte_pattern_scanner (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [wbps_pkg::RegIdxW-1:0] cfg_idx_i,
  input  logic [wbps_pkg::RegW-1:0]    cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
  input  logic                         s_axis_tlast,  // last_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [31:0]                  m_axis_tdata,  // [31:0] match_offset
  output logic                         m_axis_tuser   // found
);
  import wbps_pkg::*;

  cfg_t                  cfg;
  logic                  s_acc;
  logic [MaxPattern-1:0] pm_d, pm_q;
  logic [OffsetBits-1:0] off_q, start;
  logic                  rep_q;
  logic                  hit;
  logic                  res_valid;
  logic                  out_valid_q;
  logic                  out_found_q;
  logic [ResOffW-1:0]    out_off_q;

  wbps_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  for (genvar j = 0; j < MaxPattern; j++) begin : g_cell
    wbps_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (s_acc),
      .clr_i   (s_axis_tlast),
      .prev_i  ((j == 0) ? 1'b1 : pm_q[(j == 0) ? 0 : j - 1]),
      .en_i    (IdxW'(j) <= cfg.len_m1),
      .wild_i  (cfg.wild[j]),
      .pat_i   (cfg.pat[j]),
      .byte_i  (s_axis_tdata),
      .match_o (pm_d[j]),
      .state_o (pm_q[j])
    );
  end

  assign hit       = pm_d[cfg.len_m1];
  assign res_valid = !rep_q && (hit || s_axis_tlast);
  assign start     = off_q - OffsetBits'(cfg.len_m1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
      rep_q <= 1'b0;
    end else if (s_acc) begin
      if (s_axis_tlast) begin
        off_q <= '0;
        rep_q <= 1'b0;
      end else begin
        off_q <= off_q + OffsetBits'(1);
        rep_q <= rep_q || hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_acc) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && res_valid) begin
      out_found_q <= hit;
      out_off_q   <= hit ? ResOffW'(start) : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_off_q;
  assign m_axis_tuser  = out_found_q;

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> (out_off_q == '0))
    else $error("not-found result carries a nonzero offset");

  a_region_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && s_axis_tlast) |=> (off_q == '0 && !rep_q && pm_q == '0))
    else $error("region state not cleared after last byte");

  a_one_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && rep_q) |-> !res_valid)
    else $error("second result in one region");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (out_valid_q && !m_axis_tready))
    else $error("input stalled without a pending result");

  a_found_sets_rep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && hit && !s_axis_tlast) |=> rep_q)
    else $error("match not recorded");

endmodule

// File: bench/tb_wildcard_byte_pattern_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_wildcard_byte_pattern_scanner
// Streams memory regions through the scanner and checks every reported match
// offset and every not-found result against a bit-accurate scan predictor.
// Directed regions cover reset values, wildcards, matches on the final byte,
// short regions, length clamping and a pattern change inside a region. Then
// random phases change the pattern between regions, plant whole and cut-off
// pattern copies in noise, and stall both stream sides at random.
// ----------------------------------------------------------------------------
module tb_wildcard_byte_pattern_scanner;
  import wbps_pkg::*;

  localparam int unsigned RandomBytes = 1820;
  localparam int unsigned PhaseBytes  = 150;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned IdlePct     = 9;

  localparam logic [RegIdxW-1:0] RegSpare6 = 3'd6;
  localparam logic [RegIdxW-1:0] RegSpare7 = 3'd7;

  typedef struct packed {
    logic               found;
    logic [ResOffW-1:0] offset;
  } scan_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [RegIdxW-1:0]  cfg_idx_i     = '0;
  logic [RegW-1:0]     cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [31:0]         m_axis_tdata;
  logic                m_axis_tuser;

  // scanner configuration as the block holds it
  logic [RegW-1:0]       pat_regs [NumPatRegs] = '{default: '0};
  logic [WildW-1:0]      wild_reg    = '0;
  logic [LenW-1:0]       pat_len_reg = 6'd1;

  // per-region scan state
  logic [MaxPattern-1:0] chain_bits  = '0;
  logic [OffsetBits-1:0] next_offset = '0;
  logic                  hit_seen    = 1'b0;

  scan_result_t          expected_q[$];
  int unsigned           bytes_sent = 0;
  int unsigned           fail_count = 0;
  bit                    idle_on    = 1'b1;

  wildcard_byte_pattern_scanner dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned pattern_len_eff();
    if (pat_len_reg == 0) return 1;
    if (pat_len_reg > MaxPattern) return MaxPattern;
    return pat_len_reg;
  endfunction

  function automatic logic [ByteW-1:0] pattern_byte(input int unsigned pos);
    return pat_regs[pos / BytesPerReg][(pos % BytesPerReg) * ByteW +: ByteW];
  endfunction

  function automatic void scan_step(input logic [7:0] value, input logic last);
    logic [MaxPattern-1:0] hits;
    int unsigned           len;
    int unsigned           j;
    scan_result_t          res;
    len  = pattern_len_eff();
    hits = '0;
    for (j = 0; j < len; j++) begin
      if (wild_reg[j] || pattern_byte(j) == value) hits[j] = 1'b1;
    end
    chain_bits = ((chain_bits << 1) | 1) & hits;
    if (!hit_seen && chain_bits[len-1]) begin
      res.found  = 1'b1;
      res.offset = next_offset - OffsetBits'(len - 1);
      hit_seen   = 1'b1;
      expected_q.push_back(res);
    end else if (!hit_seen && last) begin
      res.found  = 1'b0;
      res.offset = '0;
      expected_q.push_back(res);
    end
    next_offset = next_offset + 1'b1;
    if (last) begin
      chain_bits  = '0;
      next_offset = '0;
      hit_seen    = 1'b0;
    end
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic last);
    int unsigned gap;
    gap = 0;
    while (idle_on && $urandom_range(99) < IdlePct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    scan_step(value, last);
    bytes_sent++;
  endtask

  // hold the input until every result is out and the block has settled
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [RegIdxW-1:0] idx, input logic [RegW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      RegPat0, RegPat1, RegPat2, RegPat3: pat_regs[idx[1:0]] = value;
      RegWild: wild_reg = value[WildW-1:0];
      RegLen:  pat_len_reg = value[LenW-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_list(input logic [7:0] list[$]);
    int unsigned j;
    for (j = 0; j < list.size(); j++) send_byte(list[j], j == list.size() - 1);
  endtask

  task automatic test_reset_values();
    send_list('{8'h05, 8'h00});
    send_list('{8'hFF, 8'hFF});
    send_list('{8'h00});
    send_list('{8'h00, 8'h00, 8'hFF});
  endtask

  task automatic test_wildcard_pattern();
    wait_idle();
    cfg_write(RegPat0, 64'h0000_0000_EF55_ADDE);
    cfg_write(RegWild, 64'hFFFF_FFFF_0000_0004);
    cfg_write(RegLen, 64'h0000_0000_0000_00C4);
    send_list('{8'hDE, 8'hAD, 8'h13, 8'hEF, 8'h00});
    send_list('{8'h11, 8'hDE, 8'hAD, 8'hFF, 8'hEF});
    send_list('{8'hDE, 8'hDE, 8'hAD, 8'h7A, 8'hEF});
    send_list('{8'hDE, 8'hAD});
  endtask

  task automatic test_config_mid_region();
    wait_idle();
    cfg_write(RegWild, 64'h0);
    cfg_write(RegPat0, 64'h0000_0000_0000_BBAA);
    cfg_write(RegLen, 64'd2);
    send_byte(8'hAA, 1'b0);
    wait_idle();
    cfg_write(RegPat0, 64'h0000_0000_0000_CCAA);
    send_byte(8'hCC, 1'b1);
  endtask

  task automatic test_length_clamp();
    wait_idle();
    cfg_write(RegLen, 64'h0000_0000_0000_0040);
    send_list('{8'hAA});
    send_list('{8'h3F, 8'hAB});
  endtask

  task automatic send_region();
    logic [7:0]  region_q[$];
    int unsigned len;
    int unsigned size;
    int unsigned start;
    int unsigned j;
    len  = pattern_len_eff();
    size = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(1, len + 12);
    for (j = 0; j < size; j++) begin
      region_q.push_back($urandom_range(1) ? 8'($urandom_range(255))
                                           : pattern_byte($urandom_range(len - 1)));
    end
    // plant a copy of the pattern, cut off where the region ends
    if ($urandom_range(9) < 7) begin
      start = $urandom_range(size - 1);
      for (j = 0; j < len && start + j < size; j++) begin
        region_q[start + j] = wild_reg[j] ? 8'($urandom_range(255)) : pattern_byte(j);
      end
      if ($urandom_range(5) == 0) region_q[$urandom_range(size - 1)] = 8'($urandom_range(255));
    end
    send_list(region_q);
  endtask

  task automatic test_random_regions();
    int unsigned phase;
    int unsigned start_count;
    int unsigned i;
    int unsigned len;
    logic [RegW-1:0] word;
    phase = 0;
    while (bytes_sent < RandomBytes) begin
      wait_idle();
      idle_on = (phase != 3);
      cfg_write(phase[0] ? RegSpare7 : RegSpare6, {$urandom, $urandom});
      for (i = 0; i < NumPatRegs; i++) begin
        case (phase)
          0:       word = '1;
          1:       word = '0;
          default: word = {$urandom, $urandom};
        endcase
        cfg_write(RegIdxW'(RegPat0 + i), word);
      end
      case (phase)
        0: word = '0;
        1: word = '1;
        default: begin
          case ($urandom_range(3))
            0:       word = '0;
            1:       word = '1;
            2:       word = {$urandom, $urandom & $urandom & $urandom};
            default: word = {$urandom, $urandom};
          endcase
        end
      endcase
      cfg_write(RegWild, word);
      case (phase)
        0: len = 32;
        1: len = 63;
        2: len = 0;
        default: begin
          case ($urandom_range(9))
            0:       len = $urandom_range(9, 32);
            1:       len = $urandom_range(33, 63);
            2:       len = 0;
            default: len = $urandom_range(1, 8);
          endcase
        end
      endcase
      word = {$urandom, $urandom};
      word[LenW-1:0] = LenW'(len);
      cfg_write(RegLen, word);
      start_count = bytes_sent;
      while (bytes_sent - start_count < PhaseBytes) send_region();
      phase++;
    end
    idle_on = 1'b1;
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= !(idle_on && $urandom_range(99) < IdlePct);
  end

  always @(posedge clk_i) begin : check_results
    scan_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: found=%0b match_offset=%0d", m_axis_tuser, m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tuser !== want.found) begin
          $error("found: expected %0b, actual %0b", want.found, m_axis_tuser);
          fail_count++;
        end
        if (m_axis_tdata !== want.offset) begin
          $error("match_offset: expected %0d, actual %0d", want.offset, m_axis_tdata);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned stalled;
    stalled = 0;
    while (stalled < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("tb_wildcard_byte_pattern_scanner: FAIL");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_wildcard_pattern();
    test_config_mid_region();
    test_length_clamp();
    test_random_regions();
    wait_idle();
    if (fail_count == 0) begin
      $display("tb_wildcard_byte_pattern_scanner: PASS");
    end else begin
      $display("tb_wildcard_byte_pattern_scanner: FAIL");
    end
    $finish;
  end

endmodule
